// File: rtl/tet_circumcenter_assert.svh
// ----------------------------------------------------------------------------
// tet_circumcenter assertion macros
// Shared property shorthands clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TET_CIRCUMCENTER_ASSERT_SVH
`define TET_CIRCUMCENTER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define TC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tet_circumcenter check failed");

// consequent holds in the cycle the antecedent holds
`define TC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tet_circumcenter implication failed");

// consequent holds once the delay dly has passed after the antecedent
`define TC_ASSERT_DLY(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error("tet_circumcenter delayed check failed");

`endif

// File: rtl/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg
// Types, widths and helpers for the tetrahedron circumcenter pipeline.
// ----------------------------------------------------------------------------
package tc_pkg;

	localparam int CW    = 32;   // coordinate width
	localparam int DW    = 33;   // edge vector component
	localparam int PW    = 66;   // edge component product
	localparam int XW    = 67;   // cross product and squared length
	localparam int SPLIT = 34;   // low part width for wide multiplies
	localparam int HW    = XW - SPLIT;
	localparam int TW    = 100;  // one term of the triple product
	localparam int DENW  = 103;  // twice the triple product
	localparam int PRW   = 134;  // one term of the numerator
	localparam int NUMW  = 136;  // numerator
	localparam int QB    = 33;   // quotient bits below the overflow bound
	localparam int LATENCY = 44; // delay from an accepted start to its done

	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] bz;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
	} in_t;

	typedef struct packed {
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic signed [CW-1:0] center_z;
		logic                 degenerate;
		logic                 saturated;
	} out_t;

	typedef struct packed {
		logic vld;
		logic deg;
	} div_ctl_t;

	typedef struct packed {
		logic            ok;
		logic [NUMW-1:0] rem;
	} step_t;

	// one restoring division step against a pre-shifted divisor
	function automatic step_t div_step(input logic [NUMW-1:0] rem,
			input logic [NUMW-1:0] dsh);
		logic [NUMW:0] trial;
		step_t r;
		trial = {1'b0, rem} - {1'b0, dsh};
		r.ok  = ~trial[NUMW];
		r.rem = r.ok ? trial[NUMW-1:0] : rem;
		return r;
	endfunction

endpackage

// File: rtl/tet_circumcenter.sv
// ----------------------------------------------------------------------------
// tet_circumcenter
// Circumcenter of a tetrahedron given as four Q16.16 vertices.
// ----------------------------------------------------------------------------
// One item is taken every clock; busy is always low. Each result appears on
// res with done high in start order, after eight stages form the edge
// vectors, cross products, squared lengths, split multiplies and sums, the
// divider registers its operands, a 33-stage restoring divider gives one
// quotient bit per stage, and two stages add the first vertex and
// saturate.
// The receiver cannot stall and must take res in the cycle done is high.
// ----------------------------------------------------------------------------
module tet_circumcenter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tc_pkg::in_t   vtx,
	output logic          done,
	output tc_pkg::out_t  res
);

	localparam int CW    = tc_pkg::CW;
	localparam int DW    = tc_pkg::DW;
	localparam int PW    = tc_pkg::PW;
	localparam int XW    = tc_pkg::XW;
	localparam int SPLIT = tc_pkg::SPLIT;
	localparam int HW    = tc_pkg::HW;
	localparam int TW    = tc_pkg::TW;
	localparam int DENW  = tc_pkg::DENW;
	localparam int PRW   = tc_pkg::PRW;
	localparam int NUMW  = tc_pkg::NUMW;

	// cross product pairs: x1 = ba x ca, x2 = da x ba, x3 = ca x da
	localparam int XU [3] = '{0, 2, 1};
	localparam int XV [3] = '{1, 0, 2};
	localparam int NJ [3] = '{1, 2, 0};
	localparam int NK [3] = '{2, 0, 1};

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// stage 1: input register
	tc_pkg::in_t in_s1;
	always_ff @(posedge clk) in_s1 <= vtx;

	logic signed [CW-1:0] va [3];
	logic signed [CW-1:0] vp [3][3];
	always_comb begin
		va[0] = in_s1.ax; va[1] = in_s1.ay; va[2] = in_s1.az;
		vp[0][0] = in_s1.bx; vp[0][1] = in_s1.by; vp[0][2] = in_s1.bz;
		vp[1][0] = in_s1.cx; vp[1][1] = in_s1.cy; vp[1][2] = in_s1.cz;
		vp[2][0] = in_s1.dx; vp[2][1] = in_s1.dy; vp[2][2] = in_s1.dz;
	end

	// stage 2: edge vectors ba, ca, da
	logic signed [DW-1:0] e_s2 [3][3];
	logic signed [CW-1:0] a_s2 [3], a_s3 [3], a_s4 [3], a_s5 [3], a_s6 [3];
	logic signed [CW-1:0] a_s7 [3], a_s8 [3];
	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++)
			for (int i = 0; i < 3; i++)
				e_s2[n][i] <= DW'(vp[n][i]) - DW'(va[i]);
		a_s2 <= va;
	end

	// stage 3: component products
	logic signed [PW-1:0] pa_s3 [3][3];
	logic signed [PW-1:0] pb_s3 [3][3];
	logic signed [PW-1:0] sq_s3 [3][3];
	logic signed [DW-1:0] ba_s3 [3];
	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			for (int i = 0; i < 3; i++) begin
				pa_s3[n][i] <= PW'(e_s2[XU[n]][NJ[i]]) * PW'(e_s2[XV[n]][NK[i]]);
				pb_s3[n][i] <= PW'(e_s2[XU[n]][NK[i]]) * PW'(e_s2[XV[n]][NJ[i]]);
				sq_s3[n][i] <= PW'(e_s2[n][i]) * PW'(e_s2[n][i]);
			end
		end
		ba_s3 <= e_s2[0];
		a_s3  <= a_s2;
	end

	// stage 4: cross products and squared lengths (s1 = |da|^2 first)
	logic signed [XW-1:0] x_s4 [3][3];
	logic signed [XW-1:0] s_s4 [3];
	logic signed [DW-1:0] ba_s4 [3];
	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			for (int i = 0; i < 3; i++)
				x_s4[n][i] <= XW'(pa_s3[n][i]) - XW'(pb_s3[n][i]);
			s_s4[n] <= XW'(sq_s3[2-n][0]) + XW'(sq_s3[2-n][1]) + XW'(sq_s3[2-n][2]);
		end
		ba_s4 <= ba_s3;
		a_s4  <= a_s3;
	end

	// stage 5: split partial products
	logic signed [2*SPLIT+1:0]  ll_s5 [3][3];
	logic signed [SPLIT+HW:0]   lh_s5 [3][3];
	logic signed [SPLIT+HW:0]   hl_s5 [3][3];
	logic signed [2*HW-1:0]     hh_s5 [3][3];
	logic signed [DW+SPLIT:0]   tl_s5 [3];
	logic signed [DW+HW-1:0]    th_s5 [3];
	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			for (int i = 0; i < 3; i++) begin
				ll_s5[n][i] <= (2*SPLIT+2)'($signed({1'b0, s_s4[n][SPLIT-1:0]}))
					* (2*SPLIT+2)'($signed({1'b0, x_s4[n][i][SPLIT-1:0]}));
				lh_s5[n][i] <= (SPLIT+HW+1)'($signed({1'b0, s_s4[n][SPLIT-1:0]}))
					* (SPLIT+HW+1)'($signed(x_s4[n][i][XW-1:SPLIT]));
				hl_s5[n][i] <= (SPLIT+HW+1)'($signed(s_s4[n][XW-1:SPLIT]))
					* (SPLIT+HW+1)'($signed({1'b0, x_s4[n][i][SPLIT-1:0]}));
				hh_s5[n][i] <= (2*HW)'($signed(s_s4[n][XW-1:SPLIT]))
					* (2*HW)'($signed(x_s4[n][i][XW-1:SPLIT]));
			end
		end
		for (int i = 0; i < 3; i++) begin
			tl_s5[i] <= (DW+SPLIT+1)'(ba_s4[i])
				* (DW+SPLIT+1)'($signed({1'b0, x_s4[2][i][SPLIT-1:0]}));
			th_s5[i] <= (DW+HW)'(ba_s4[i]) * (DW+HW)'($signed(x_s4[2][i][XW-1:SPLIT]));
		end
		a_s5 <= a_s4;
	end

	// stage 6: whole products
	logic signed [PRW-1:0] pr_s6 [3][3];
	logic signed [TW-1:0]  tr_s6 [3];
	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++)
			for (int i = 0; i < 3; i++)
				pr_s6[n][i] <= (PRW'(hh_s5[n][i]) <<< (2*SPLIT))
					+ ((PRW'(lh_s5[n][i]) + PRW'(hl_s5[n][i])) <<< SPLIT)
					+ PRW'(ll_s5[n][i]);
		for (int i = 0; i < 3; i++)
			tr_s6[i] <= (TW'(th_s5[i]) <<< SPLIT) + TW'(tl_s5[i]);
		a_s6 <= a_s5;
	end

	// stage 7: numerators and denominator
	logic signed [NUMW-1:0] num_s7 [3];
	logic signed [DENW-1:0] den_s7;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			num_s7[i] <= NUMW'(pr_s6[0][i]) + NUMW'(pr_s6[1][i]) + NUMW'(pr_s6[2][i]);
		den_s7 <= (DENW'(tr_s6[0]) + DENW'(tr_s6[1]) + DENW'(tr_s6[2])) <<< 1;
		a_s7 <= a_s6;
	end

	// stage 8: magnitudes and quotient signs
	logic [NUMW-1:0] nmag_s8 [3];
	logic [DENW-1:0] dmag_s8;
	logic            neg_s8 [3];
	logic            deg_s8;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nmag_s8[i] <= num_s7[i][NUMW-1] ? NUMW'(-num_s7[i]) : NUMW'(num_s7[i]);
			neg_s8[i]  <= num_s7[i][NUMW-1] ^ den_s7[DENW-1];
		end
		dmag_s8 <= den_s7[DENW-1] ? DENW'(-den_s7) : DENW'(den_s7);
		deg_s8  <= (den_s7 == '0);
		a_s8    <= a_s7;
	end

	tc_pkg::div_ctl_t ctl_s8;
	always_comb begin
		ctl_s8.vld = vld_s8;
		ctl_s8.deg = deg_s8;
	end

	tc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s8),
		.nmag   (nmag_s8),
		.dmag   (dmag_s8),
		.neg    (neg_s8),
		.a      (a_s8),
		.done   (done),
		.res    (res)
	);

endmodule

// File: rtl/tc_div.sv
// ----------------------------------------------------------------------------
// tc_div
// Pipelined restoring divider for the three center coordinates, one quotient
// bit per stage, followed by sign restore, offset add and saturation.
// ----------------------------------------------------------------------------
module tc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tc_pkg::div_ctl_t                ctl,
	input  logic [tc_pkg::NUMW-1:0]         nmag [3],
	input  logic [tc_pkg::DENW-1:0]         dmag,
	input  logic                            neg [3],
	input  logic signed [tc_pkg::CW-1:0]    a [3],
	output logic                            done,
	output tc_pkg::out_t                    res
);

	localparam int QB = tc_pkg::QB;

	tc_pkg::div_ctl_t               ctl_s [0:QB+2];
	logic [tc_pkg::NUMW-1:0]        rem_s [0:QB][3];
	logic [QB-1:0]                  q_s   [0:QB][3];
	logic [tc_pkg::DENW-1:0]        den_s [0:QB];
	logic                           neg_s [0:QB][3];
	logic                           ovf_s [0:QB+1][3];
	logic signed [tc_pkg::CW-1:0]   a_s   [0:QB+1][3];
	logic signed [QB:0]             qs_s34 [3];
	tc_pkg::out_t                   res_s35;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB + 2; k++) ctl_s[k] <= '0;
		end else begin
			ctl_s[0] <= ctl;
			for (int k = 1; k <= QB + 2; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		den_s[0] <= dmag;
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= nmag[i];
			q_s[0][i]   <= '0;
			neg_s[0][i] <= neg[i];
			a_s[0][i]   <= a[i];
			ovf_s[0][i] <= nmag[i] >= (tc_pkg::NUMW'(dmag) << QB);
		end
		for (int k = 1; k <= QB; k++) begin
			den_s[k] <= den_s[k-1];
			for (int i = 0; i < 3; i++) begin
				tc_pkg::step_t st;
				st = tc_pkg::div_step(rem_s[k-1][i],
					tc_pkg::NUMW'(den_s[k-1]) << (QB - k));
				rem_s[k][i] <= st.rem;
				q_s[k][i]   <= q_s[k-1][i] | (QB'(st.ok) << (QB - k));
				neg_s[k][i] <= neg_s[k-1][i];
				a_s[k][i]   <= a_s[k-1][i];
				ovf_s[k][i] <= ovf_s[k-1][i];
			end
		end
		for (int i = 0; i < 3; i++) begin
			qs_s34[i]      <= neg_s[QB][i] ? -$signed({1'b0, q_s[QB][i]})
				: $signed({1'b0, q_s[QB][i]});
			a_s[QB+1][i]   <= a_s[QB][i];
			ovf_s[QB+1][i] <= ovf_s[QB][i] | (neg_s[QB][i] & 1'b0);
		end
	end

	// sign of an overflowed quotient is kept in qs_s34 only when it fits,
	// so the sign travels separately
	logic neg_s34 [3];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) neg_s34[i] <= neg_s[QB][i];
	end

	logic signed [tc_pkg::CW-1:0] cc [3];
	logic                         sc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [QB+1:0] sum;
			sum = (QB+2)'(a_s[QB+1][i]) + (QB+2)'(qs_s34[i]);
			sc[i] = 1'b1;
			if (ovf_s[QB+1][i]) begin
				cc[i] = neg_s34[i] ? tc_pkg::C_MIN : tc_pkg::C_MAX;
			end else if (sum > (QB+2)'(tc_pkg::C_MAX)) begin
				cc[i] = tc_pkg::C_MAX;
			end else if (sum < (QB+2)'(tc_pkg::C_MIN)) begin
				cc[i] = tc_pkg::C_MIN;
			end else begin
				cc[i] = sum[tc_pkg::CW-1:0];
				sc[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s[QB+1].deg) begin
			res_s35.center_x   <= '0;
			res_s35.center_y   <= '0;
			res_s35.center_z   <= '0;
			res_s35.degenerate <= 1'b1;
			res_s35.saturated  <= 1'b0;
		end else begin
			res_s35.center_x   <= cc[0];
			res_s35.center_y   <= cc[1];
			res_s35.center_z   <= cc[2];
			res_s35.degenerate <= 1'b0;
			res_s35.saturated  <= sc[0] | sc[1] | sc[2];
		end
	end

	assign done = ctl_s[QB+2].vld;
	assign res  = res_s35;

endmodule

// File: rtl/tc_chk.sv
// ----------------------------------------------------------------------------
// tc_chk
// Port level checks for tet_circumcenter, bound to the top level.
// ----------------------------------------------------------------------------
`include "tet_circumcenter_assert.svh"

module tc_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input tc_pkg::out_t  res
);

	logic acc;
	logic deg_ok;
	logic sat_ok;

	assign acc    = start && !busy;
	assign deg_ok = res.center_x == '0 && res.center_y == '0 && res.center_z == '0
		&& !res.saturated;
	assign sat_ok = res.center_x == tc_pkg::C_MAX || res.center_x == tc_pkg::C_MIN
		|| res.center_y == tc_pkg::C_MAX || res.center_y == tc_pkg::C_MIN
		|| res.center_z == tc_pkg::C_MAX || res.center_z == tc_pkg::C_MIN;

	`TC_ASSERT(a_never_busy, !busy)
	`TC_ASSERT_IMPL(a_deg_zero, done && res.degenerate, deg_ok)
	`TC_ASSERT_IMPL(a_sat_bound, done && res.saturated, sat_ok)
	`TC_ASSERT_DLY(a_latency, acc, tc_pkg::LATENCY, done)

endmodule

bind tet_circumcenter tc_chk u_chk (.*);

// File: verif/tet_circumcenter_tb.sv
// ----------------------------------------------------------------------------
// tet_circumcenter_tb
// Drives tetrahedra into the circumcenter pipeline with random gaps and checks
// each center, degenerate and saturated flag against an exact wide-integer
// computation done in the bench.
// ----------------------------------------------------------------------------
module tet_circumcenter_tb;

	localparam int WATCHDOG = 2000;

	logic          clk;
	logic          arst_n;
	logic          start;
	tc_pkg::in_t   vtx;
	logic          busy;
	logic          done;
	tc_pkg::out_t  res;

	tc_pkg::in_t   tet_q[$];
	int            gap_q[$];
	tc_pkg::out_t  center_q[$];
	int            errors;
	bit            stim_done;
	int            gap_left;
	int            idle_cycles;

	tet_circumcenter DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vtx(vtx), .done(done), .res(res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact circumcenter with truncating division and saturation
	function automatic tc_pkg::out_t circumcenter(input tc_pkg::in_t t);
		logic signed [255:0] ba[3], ca[3], da[3], x1[3], x2[3], x3[3];
		logic signed [255:0] a[3], den, s1, s2, s3, num, c;
		tc_pkg::out_t r;
		a[0] = t.ax; a[1] = t.ay; a[2] = t.az;
		ba[0] = t.bx - a[0]; ba[1] = t.by - a[1]; ba[2] = t.bz - a[2];
		ca[0] = t.cx - a[0]; ca[1] = t.cy - a[1]; ca[2] = t.cz - a[2];
		da[0] = t.dx - a[0]; da[1] = t.dy - a[1]; da[2] = t.dz - a[2];
		x1[0] = ba[1]*ca[2] - ba[2]*ca[1];
		x1[1] = ba[2]*ca[0] - ba[0]*ca[2];
		x1[2] = ba[0]*ca[1] - ba[1]*ca[0];
		x2[0] = da[1]*ba[2] - da[2]*ba[1];
		x2[1] = da[2]*ba[0] - da[0]*ba[2];
		x2[2] = da[0]*ba[1] - da[1]*ba[0];
		x3[0] = ca[1]*da[2] - ca[2]*da[1];
		x3[1] = ca[2]*da[0] - ca[0]*da[2];
		x3[2] = ca[0]*da[1] - ca[1]*da[0];
		den = 2 * (ba[0]*x3[0] + ba[1]*x3[1] + ba[2]*x3[2]);
		r = '0;
		if (den == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		s1 = da[0]*da[0] + da[1]*da[1] + da[2]*da[2];
		s2 = ca[0]*ca[0] + ca[1]*ca[1] + ca[2]*ca[2];
		s3 = ba[0]*ba[0] + ba[1]*ba[1] + ba[2]*ba[2];
		for (int i = 0; i < 3; i++) begin
			num = s1*x1[i] + s2*x2[i] + s3*x3[i];
			c = a[i] + num / den;
			if (c > 256'sd2147483647) begin
				c = 256'sd2147483647;
				r.saturated = 1'b1;
			end else if (c < -256'sd2147483648) begin
				c = -256'sd2147483648;
				r.saturated = 1'b1;
			end
			if (i == 0) r.center_x = c[31:0];
			else if (i == 1) r.center_y = c[31:0];
			else r.center_z = c[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic [31:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 2000) - 1000;
			2: return ($urandom_range(0, 200) - 100) << 16;
			default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
				: 32'h80000000 + $urandom_range(0, 3);
		endcase
	endfunction

	function automatic tc_pkg::in_t rnd_tet();
		tc_pkg::in_t t;
		int m;
		m = $urandom_range(0, 9);
		if (m < 3) begin
			t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom()};
		end else if (m < 8) begin
			// small well-formed tetrahedron around a random base point
			t.ax = rnd_coord(m == 7 ? 0 : 2); t.ay = rnd_coord(2); t.az = rnd_coord(1);
			t.bx = t.ax + rnd_coord(1) * 64; t.by = t.ay + rnd_coord(1) * 64;
			t.bz = t.az + rnd_coord(1) * 64;
			t.cx = t.ax + rnd_coord(1) * 64; t.cy = t.ay + rnd_coord(1) * 64;
			t.cz = t.az + rnd_coord(1) * 64;
			t.dx = t.ax + rnd_coord(1) * 64; t.dy = t.ay + rnd_coord(1) * 64;
			t.dz = t.az + rnd_coord(1) * 64;
		end else if (m == 8) begin
			t = {rnd_coord(3), rnd_coord(3), rnd_coord(3), rnd_coord(3),
				rnd_coord(3), rnd_coord(3), rnd_coord(3), rnd_coord(3),
				rnd_coord(3), rnd_coord(3), rnd_coord(3), rnd_coord(3)};
		end else begin
			// coplanar: d lies in the plane z = az
			t = {rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1),
				rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1),
				rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1)};
			t.bz = t.az; t.cz = t.az; t.dz = t.az;
		end
		return t;
	endfunction

	task automatic add_tet(input tc_pkg::in_t t, input int gap);
		tet_q = {tet_q, t};
		gap_q = {gap_q, gap};
	endtask

	function automatic int rnd_gap();
		return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
	endfunction

	initial begin
		tc_pkg::in_t t;
		errors = 0;
		arst_n = 1'b0;
		// unit tetrahedron, its mirror, scaled and shifted
		add_tet({32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
			32'sh0, 32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh10000}, rnd_gap());
		add_tet({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0,
			32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh10000}, rnd_gap());
		add_tet({32'sh1, 32'sh2, 32'sh3, 32'sh4, 32'sh2, 32'sh3,
			32'sh1, 32'sh7, 32'sh3, 32'sh1, 32'sh2, 32'sh9}, rnd_gap());
		// degenerate: all points equal, collinear, coplanar
		add_tet('0, rnd_gap());
		add_tet({12{32'sh7fffffff}}, rnd_gap());
		add_tet({12{32'sh80000000}}, rnd_gap());
		add_tet({32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh10000,
			32'sh20000, 32'sh20000, 32'sh20000, 32'sh30000, 32'sh30000, 32'sh30000},
			rnd_gap());
		add_tet({32'sh0, 32'sh0, 32'sh5, 32'sh10000, 32'sh0, 32'sh5,
			32'sh0, 32'sh10000, 32'sh5, 32'sh30000, 32'sh20000, 32'sh5}, rnd_gap());
		// extreme corners of the coordinate range
		add_tet({32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff}, rnd_gap());
		add_tet({32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000}, rnd_gap());
		// near-flat sliver, center far away
		add_tet({32'sh0, 32'sh0, 32'sh0, 32'sh7fff0000, 32'sh0, 32'sh0,
			32'sh0, 32'sh7fff0000, 32'sh0, 32'sh40000000, 32'sh40000000, 32'sh1},
			rnd_gap());
		add_tet({32'sh7fff0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			32'sh0, 32'sh80010000, 32'sh0, 32'sh1, 32'sh1, 32'shffffffff}, rnd_gap());
		for (int i = 0; i < 2000; i++) begin
			t = rnd_tet();
			add_tet(t, rnd_gap());
		end
		// tail of back-to-back items
		for (int i = 0; i < 60; i++) begin
			t = rnd_tet();
			add_tet(t, 0);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			vtx       <= '0;
			gap_left  <= 0;
			stim_done <= 1'b0;
		end else if (start && busy) begin
			// hold the item until taken
		end else if (gap_left > 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (tet_q.size() > 0) begin
			vtx      <= tet_q.pop_front();
			gap_left <= gap_q.pop_front();
			start    <= 1'b1;
		end else begin
			start     <= 1'b0;
			stim_done <= 1'b1;
		end
	end

	// predict on acceptance, check on done
	always @(posedge clk) begin
		tc_pkg::out_t want;
		if (arst_n) begin
			if (start && !busy) center_q = {center_q, circumcenter(vtx)};
			if (done) begin
				if (center_q.size() == 0) begin
					report_mismatch("unexpected center_x", res.center_x, '0);
				end else begin
					want = center_q.pop_front();
					if (res.center_x !== want.center_x)
						report_mismatch("center_x", res.center_x, want.center_x);
					if (res.center_y !== want.center_y)
						report_mismatch("center_y", res.center_y, want.center_y);
					if (res.center_z !== want.center_z)
						report_mismatch("center_z", res.center_z, want.center_z);
					if (res.degenerate !== want.degenerate)
						report_mismatch("degenerate", res.degenerate, want.degenerate);
					if (res.saturated !== want.saturated)
						report_mismatch("saturated", res.saturated, want.saturated);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		@(posedge clk);
		while (!(stim_done === 1'b1 && center_q.size() == 0)) @(posedge clk);
		repeat (tc_pkg::LATENCY + 10) @(posedge clk);
		if (errors == 0 && center_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: tet_circumcenter.f
+incdir+rtl
rtl/tc_pkg.sv
rtl/tc_div.sv
rtl/tet_circumcenter.sv
rtl/tc_chk.sv
verif/tet_circumcenter_tb.sv
